// ----- rtl/mafp_pkg.sv -----
// Shared constants, codes, result type and helpers of the ADC frame packer.
package mafp_pkg;

    localparam int NUM_BLOCKS  = 4;
    localparam int BLOCK_BYTES = 512;
    localparam int CHANNELS    = 8;
    localparam int FRAME_BITS  = 24;
    localparam int FRAME_BYTES = 24;
    localparam int DATA_OFFSET = 2;
    localparam int MAX_FRAMES  = 21;
    localparam int FPB_RESET   = 20;

    localparam int BLK_W  = $clog2(NUM_BLOCKS);
    localparam int OFF_W  = $clog2(BLOCK_BYTES);
    localparam int ADDR_W = BLK_W + OFF_W;
    localparam int SLOT_W = $clog2(MAX_FRAMES + 1);
    localparam int DEPTH  = NUM_BLOCKS * BLOCK_BYTES;

    // Request codes carried by req_type.
    localparam logic [1:0] REQ_EDGE    = 2'd0;
    localparam logic [1:0] REQ_BIT     = 2'd1;
    localparam logic [1:0] REQ_READ    = 2'd2;
    localparam logic [1:0] REQ_RELEASE = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_REC_EN = 1'b0;
    localparam logic CFG_FPB    = 1'b1;

    typedef struct packed {
        logic [7:0] read_data;
        logic       frame_done;
        logic       block_ready;
        logic [1:0] ready_block;
        logic       overrun;
        logic [3:0] ready_mask;
    } t_result;

    // Frames per block as used: zero acts as one, large values saturate.
    function automatic logic [SLOT_W-1:0] eff_frames(input logic [4:0] fpb);
        logic [SLOT_W-1:0] f;
        if (fpb == 5'd0) begin
            f = SLOT_W'(1);
        end else if (32'(fpb) > MAX_FRAMES) begin
            f = SLOT_W'(MAX_FRAMES);
        end else begin
            f = SLOT_W'(fpb);
        end
        return f;
    endfunction

endpackage

// ----- rtl/mafp_byte_ram.sv -----
// Byte-wide block buffer memory with one write port and one registered read port.
module mafp_byte_ram
    import mafp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ----- rtl/multichannel_adc_frame_packer_unit.sv -----
// Top level of the ADC frame packer: capture, block ring control and result register.
// A result passes the result register and then the output register; a byte read first passes
// the read state. A new word is taken only in idle with no result waiting; a completed
// frame stored with recording on runs a 24-byte write into the buffer memory (one byte per
// cycle on its write port), and no word is taken until that write ends.
// Reset (synchronous, active low) clears all control state and ready flags; buffer contents
// are not cleared, and bytes never written since reset read back as zero.
module multichannel_adc_frame_packer_unit
    import mafp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Configuration write port.
    input  logic       i_cfg_wr_en,
    input  logic       i_cfg_idx,
    input  logic [4:0] i_cfg_wr_data,
    // Request channel.
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_req_type,
    input  logic [7:0] i_data_lines,
    input  logic [1:0] i_block_index,
    input  logic [8:0] i_byte_offset,
    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_read_data,
    output logic       o_frame_done,
    output logic       o_block_ready,
    output logic [1:0] o_ready_block,
    output logic       o_overrun,
    output logic [3:0] o_ready_mask
);

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_READ  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    // Configuration registers.
    logic              r_rec_en;
    logic [4:0]        r_fpb;

    // Sequencer, capture and ring state.
    logic [1:0]        r_state,   n_state;
    logic              r_toggle,  n_toggle;
    logic              r_active,  n_active;
    logic [4:0]        r_bit_cnt, n_bit_cnt;
    logic [23:0]       r_shift    [8];
    logic [23:0]       n_shift    [8];
    logic [SLOT_W-1:0] r_slot,    n_slot;
    logic [BLK_W-1:0]  r_wb,      n_wb;
    logic [NUM_BLOCKS-1:0] r_ready, n_ready;
    // One bit per frame slot of each block: set when a frame lands there, cleared on
    // release. A clear bit reads as zero, which stands in for the release's zero fill.
    logic [MAX_FRAMES-1:0] r_slot_vld [NUM_BLOCKS];
    logic [MAX_FRAMES-1:0] n_slot_vld [NUM_BLOCKS];

    // Frame write sequence.
    logic [ADDR_W-1:0] r_wr_addr, n_wr_addr;
    logic [2:0]        r_ch,      n_ch;
    logic [1:0]        r_byte,    n_byte;

    // Read bookkeeping and result staging.
    logic              r_rd_ok,   n_rd_ok;
    t_result           r_res,     n_res;
    logic              r_res_pend, n_res_pend;
    t_result           r_out,     n_out;
    logic              r_out_valid, n_out_valid;

    // Memory port signals.
    logic              ram_we;
    logic [7:0]        ram_wdata;
    logic              ram_re;
    logic [7:0]        ram_rdata;

    logic              in_acc;
    logic              res_set;
    logic [SLOT_W-1:0] eff;
    logic [4:0]        bit_next;
    logic [SLOT_W-1:0] slot_next;
    logic [9:0]        read_end;
    logic [8:0]        off_m2;
    logic [11:0]       slot_prod;
    logic [SLOT_W-1:0] rd_slot;
    logic              rd_range;
    logic [BLK_W-1:0]  req_blk;
    logic              blk_ok;
    logic [23:0]       cur_word;

    assign o_in_ready = (r_state == S_IDLE) && !r_res_pend;
    assign in_acc     = i_in_valid && o_in_ready;

    assign eff       = eff_frames(r_fpb);
    assign bit_next  = r_bit_cnt + 5'd1;
    assign slot_next = r_slot + SLOT_W'(1);
    assign req_blk   = i_block_index[BLK_W-1:0];
    assign blk_ok    = 32'(i_block_index) < NUM_BLOCKS;

    // Frame area of a block ends at two plus 24 bytes per frame. The slot of a read
    // offset is (offset - 2) / 24, taken as ((offset - 2) >> 3) / 3 with a reciprocal
    // multiply by 43/128, exact for the six-bit operand range here.
    assign read_end  = 10'(DATA_OFFSET) + 10'(eff) * 10'(FRAME_BYTES);
    assign off_m2    = i_byte_offset - 9'(DATA_OFFSET);
    assign slot_prod = 12'(off_m2[8:3]) * 12'd43;
    assign rd_slot   = SLOT_W'(slot_prod >> 7);
    assign rd_range  = (32'(i_byte_offset) >= DATA_OFFSET) && ({1'b0, i_byte_offset} < read_end);

    // Byte of the current channel, most significant first.
    assign cur_word = r_shift[r_ch];
    always_comb begin
        case (r_byte)
            2'd0:    ram_wdata = cur_word[23:16];
            2'd1:    ram_wdata = cur_word[15:8];
            default: ram_wdata = cur_word[7:0];
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_toggle    = r_toggle;
        n_active    = r_active;
        n_bit_cnt   = r_bit_cnt;
        n_shift     = r_shift;
        n_slot      = r_slot;
        n_wb        = r_wb;
        n_ready     = r_ready;
        n_slot_vld  = r_slot_vld;
        n_wr_addr   = r_wr_addr;
        n_ch        = r_ch;
        n_byte      = r_byte;
        n_rd_ok     = r_rd_ok;
        n_res       = r_res;
        n_res_pend  = r_res_pend;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        res_set     = 1'b0;

        // The result register drains into the output register whenever that is free
        // or being emptied in this cycle.
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (r_res_pend && (!r_out_valid || i_out_ready)) begin
            n_out       = r_res;
            n_out_valid = 1'b1;
            n_res_pend  = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_res   = '0;
                    res_set = 1'b1;
                    case (i_req_type)
                        REQ_EDGE: begin
                            // Every other data-ready edge is kept, the first is dropped.
                            n_toggle = ~r_toggle;
                            if (r_toggle) begin
                                for (int c = 0; c < 8; c++) begin
                                    n_shift[c] = '0;
                                end
                                n_bit_cnt = '0;
                                n_active  = 1'b1;
                            end
                        end
                        REQ_BIT: begin
                            if (r_active) begin
                                for (int c = 0; c < 8; c++) begin
                                    if (c < CHANNELS) begin
                                        n_shift[c] = {r_shift[c][22:0], i_data_lines[c]};
                                    end
                                end
                                n_bit_cnt = bit_next;
                                if (32'(bit_next) >= FRAME_BITS) begin
                                    n_active         = 1'b0;
                                    n_bit_cnt        = '0;
                                    n_res.frame_done = 1'b1;
                                    if (r_rec_en) begin
                                        n_res.overrun          = r_ready[r_wb];
                                        n_slot_vld[r_wb][r_slot] = 1'b1;
                                        n_wr_addr = {r_wb,
                                                     OFF_W'(DATA_OFFSET + 32'(r_slot) * FRAME_BYTES)};
                                        n_ch      = '0;
                                        n_byte    = '0;
                                        n_state   = S_WRITE;
                                        if (slot_next >= eff) begin
                                            n_ready[r_wb]     = 1'b1;
                                            n_res.block_ready = 1'b1;
                                            n_res.ready_block = 2'(r_wb);
                                            n_wb              = r_wb + BLK_W'(1);
                                            n_slot            = '0;
                                        end else begin
                                            n_slot = slot_next;
                                        end
                                    end
                                end
                            end
                        end
                        REQ_READ: begin
                            // The byte comes back next cycle; the slot check is kept till then.
                            res_set = 1'b0;
                            ram_re  = 1'b1;
                            n_rd_ok = blk_ok && rd_range && r_slot_vld[req_blk][rd_slot];
                            n_state = S_READ;
                        end
                        REQ_RELEASE: begin
                            if (blk_ok) begin
                                n_ready[req_blk]    = 1'b0;
                                n_slot_vld[req_blk] = '0;
                            end
                        end
                        default: begin
                        end
                    endcase
                    if (res_set) begin
                        n_res_pend = 1'b1;
                    end
                end
            end
            S_READ: begin
                n_res           = '0;
                n_res.read_data = r_rd_ok ? ram_rdata : 8'd0;
                res_set         = 1'b1;
                n_res_pend      = 1'b1;
                n_state         = S_IDLE;
            end
            S_WRITE: begin
                // One byte per cycle: three bytes per channel, channels in order.
                ram_we    = 1'b1;
                n_wr_addr = r_wr_addr + ADDR_W'(1);
                if (r_byte == 2'd2) begin
                    n_byte = '0;
                    n_ch   = r_ch + 3'd1;
                    if (r_ch == 3'd7) begin
                        n_state = S_IDLE;
                    end
                end else begin
                    n_byte = r_byte + 2'd1;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (res_set) begin
            n_res.ready_mask = 4'(n_ready);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rec_en    <= 1'b0;
            r_fpb       <= 5'(FPB_RESET);
            r_state     <= S_IDLE;
            r_toggle    <= 1'b0;
            r_active    <= 1'b0;
            r_bit_cnt   <= '0;
            r_slot      <= '0;
            r_wb        <= '0;
            r_ready     <= '0;
            for (int b = 0; b < NUM_BLOCKS; b++) begin
                r_slot_vld[b] <= '0;
            end
            r_res_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_idx)
                    CFG_REC_EN: r_rec_en <= i_cfg_wr_data[0];
                    CFG_FPB:    r_fpb    <= i_cfg_wr_data;
                    default: begin
                    end
                endcase
            end
            r_state     <= n_state;
            r_toggle    <= n_toggle;
            r_active    <= n_active;
            r_bit_cnt   <= n_bit_cnt;
            r_slot      <= n_slot;
            r_wb        <= n_wb;
            r_ready     <= n_ready;
            r_slot_vld  <= n_slot_vld;
            r_res_pend  <= n_res_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_shift   <= n_shift;
        r_wr_addr <= n_wr_addr;
        r_ch      <= n_ch;
        r_byte    <= n_byte;
        r_rd_ok   <= n_rd_ok;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    mafp_byte_ram u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (r_wr_addr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr ({req_blk, i_byte_offset}),
        .o_rd_data (ram_rdata)
    );

    assign o_out_valid   = r_out_valid;
    assign o_read_data   = r_out.read_data;
    assign o_frame_done  = r_out.frame_done;
    assign o_block_ready = r_out.block_ready;
    assign o_ready_block = r_out.ready_block;
    assign o_overrun     = r_out.overrun;
    assign o_ready_mask  = r_out.ready_mask;

endmodule

// ----- dv/mafp_ring_check_pkg.sv -----
// Scoreboard class that predicts and checks the frame packer's result words.
package mafp_ring_check_pkg;
    import mafp_pkg::*;

    class frame_ring_tracker;
        bit                  rec_en;
        bit [4:0]            fpb;
        bit                  keep_toggle;
        bit                  frame_active;
        int                  bit_count;
        bit [23:0]           shift_reg [8];
        int                  fill_bytes;
        bit [BLK_W-1:0]      write_block;
        bit [NUM_BLOCKS-1:0] ready_flags;
        bit [7:0]            ring_bytes [DEPTH];
        t_result             pending_results [$];
        int                  error_count;

        function new();
            rec_en       = 1'b0;
            fpb          = 5'(FPB_RESET);
            keep_toggle  = 1'b0;
            frame_active = 1'b0;
            bit_count    = 0;
            fill_bytes   = 0;
            write_block  = '0;
            ready_flags  = '0;
            error_count  = 0;
            foreach (shift_reg[c]) shift_reg[c] = '0;
            foreach (ring_bytes[a]) ring_bytes[a] = '0;
        endfunction

        // Bytes of a block that hold frame data under the current setting.
        function int area_limit();
            int f;
            f = int'(fpb);
            if (f < 1) f = 1;
            if (f > MAX_FRAMES) f = MAX_FRAMES;
            return f * FRAME_BYTES;
        endfunction

        function void write_cfg(logic idx, logic [4:0] val);
            if (idx == CFG_REC_EN) rec_en = val[0];
            else fpb = val;
        endfunction

        function void note_word(logic [1:0] req, logic [7:0] lines, logic [1:0] blk,
                                logic [8:0] off);
            t_result r;
            int      base;
            r = '0;
            case (req)
                REQ_EDGE: begin
                    keep_toggle = ~keep_toggle;
                    if (!keep_toggle) begin
                        foreach (shift_reg[c]) shift_reg[c] = '0;
                        bit_count    = 0;
                        frame_active = 1'b1;
                    end
                end
                REQ_BIT: begin
                    if (frame_active) begin
                        for (int c = 0; c < CHANNELS; c++)
                            shift_reg[c] = {shift_reg[c][22:0], lines[c]};
                        bit_count++;
                        if (bit_count >= FRAME_BITS) begin
                            frame_active = 1'b0;
                            bit_count    = 0;
                            r.frame_done = 1'b1;
                            if (rec_en) begin
                                base = int'(write_block) * BLOCK_BYTES + DATA_OFFSET + fill_bytes;
                                r.overrun = ready_flags[write_block];
                                for (int c = 0; c < 8; c++) begin
                                    ring_bytes[base + 3*c]     = shift_reg[c][23:16];
                                    ring_bytes[base + 3*c + 1] = shift_reg[c][15:8];
                                    ring_bytes[base + 3*c + 2] = shift_reg[c][7:0];
                                end
                                fill_bytes += FRAME_BYTES;
                                if (fill_bytes >= area_limit()) begin
                                    ready_flags[write_block] = 1'b1;
                                    r.block_ready = 1'b1;
                                    r.ready_block = write_block;
                                    write_block = BLK_W'((int'(write_block) + 1) % NUM_BLOCKS);
                                    fill_bytes  = 0;
                                end
                            end
                        end
                    end
                end
                REQ_READ: begin
                    if (int'(off) >= DATA_OFFSET && int'(off) < DATA_OFFSET + area_limit())
                        r.read_data = ring_bytes[int'(blk) * BLOCK_BYTES + int'(off)];
                end
                REQ_RELEASE: begin
                    ready_flags[blk] = 1'b0;
                    for (int b = 0; b < BLOCK_BYTES; b++)
                        ring_bytes[int'(blk) * BLOCK_BYTES + b] = '0;
                end
                default: ;
            endcase
            r.ready_mask = 4'(ready_flags);
            pending_results.push_back(r);
        endfunction

        function void compare_field(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                error_count++;
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (pending_results.size() == 0) begin
                $error("result word %h arrived with nothing outstanding", got);
                error_count++;
                return;
            end
            want = pending_results.pop_front();
            compare_field("read_data", want.read_data, got.read_data);
            compare_field("frame_done", want.frame_done, got.frame_done);
            compare_field("block_ready", want.block_ready, got.block_ready);
            compare_field("ready_block", want.ready_block, got.ready_block);
            compare_field("overrun", want.overrun, got.overrun);
            compare_field("ready_mask", want.ready_mask, got.ready_mask);
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

endpackage

// ----- dv/tb.sv -----
// Self-checking testbench of the multichannel ADC frame packer.
module tb
    import mafp_pkg::*, mafp_ring_check_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any word moving on either channel before the run is abandoned.
    localparam int WATCHDOG_LIMIT = 3000;
    // Quiet time after the last result, so that a stored frame's byte writes into the buffer run out.
    localparam int SETTLE_CYCLES  = 30;
    localparam int N_PHASES       = 7;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic       i_cfg_idx     = 1'b0;
    logic [4:0] i_cfg_wr_data = '0;
    logic       i_in_valid    = 1'b0;
    logic       o_in_ready;
    logic [1:0] i_req_type    = '0;
    logic [7:0] i_data_lines  = '0;
    logic [1:0] i_block_index = '0;
    logic [8:0] i_byte_offset = '0;
    logic       o_out_valid;
    logic       i_out_ready   = 1'b0;
    logic [7:0] o_read_data;
    logic       o_frame_done;
    logic       o_block_ready;
    logic [1:0] o_ready_block;
    logic       o_overrun;
    logic [3:0] o_ready_mask;

    frame_ring_tracker sb;
    t_result           got_word;
    int                idle_cycles    = 0;
    int                words_sent     = 0;
    int                send_idle_pct  = 0;
    int                recv_stall_pct = 0;

    // Random phases: recording, frames per block, words, share of releases among the
    // words slipped into a frame. The sequence walks through the extremes of the frame
    // count: zero acting as one, 21 left part-filled and then lowered to 2 so that the
    // fill already reaches the block size, and 31 saturating while recording is off.
    // The first two phases slip no releases into a frame, so that the ring fills up and overruns.
    int ph_rec   [N_PHASES] = '{1, 1, 1, 1, 0, 1, 1};
    int ph_fpb   [N_PHASES] = '{1, 0, 21, 2, 31, 3, 20};
    int ph_words [N_PHASES] = '{110, 60, 80, 30, 20, 30, 20};
    int ph_rel   [N_PHASES] = '{0, 0, 35, 35, 35, 35, 35};

    multichannel_adc_frame_packer_unit DUT (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // The receiver decides afresh at every falling edge whether it will take a word.
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Every result word accepted at a rising edge is checked against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_word.read_data   = o_read_data;
            got_word.frame_done  = o_frame_done;
            got_word.block_ready = o_block_ready;
            got_word.ready_block = o_ready_block;
            got_word.overrun     = o_overrun;
            got_word.ready_mask  = o_ready_mask;
            sb.check_result(got_word);
        end
    end

    // The watchdog is cleared by any word moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Offers one request word and returns at the falling edge after its acceptance.
    // Valid stays high on return, so that back-to-back words need no lowering of it.
    task automatic send_word(input logic [1:0] req, input logic [7:0] lines,
                             input logic [1:0] blk, input logic [8:0] off);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_req_type    <= req;
        i_data_lines  <= lines;
        i_block_index <= blk;
        i_byte_offset <= off;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_word(req, lines, blk, off);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Reads mostly land inside the frame area of a block, the rest anywhere in it.
    task automatic rand_read();
        logic [8:0] off;
        if ($urandom_range(99) < 70) begin
            off = 9'(DATA_OFFSET + $urandom_range(sb.area_limit() - 1));
        end else begin
            off = 9'($urandom);
        end
        send_word(REQ_READ, 8'($urandom), 2'($urandom), off);
    endtask

    // Brings the edge toggle round to a kept edge and then shifts in nbits bit samples.
    // Now and then a read, a release or a dropped edge is slipped in between the bits;
    // none of them may disturb the frame being captured.
    task automatic run_frame(input int nbits, input int rel_pct);
        int pick;
        if (!sb.keep_toggle) send_word(REQ_EDGE, 8'($urandom), 2'($urandom), 9'($urandom));
        send_word(REQ_EDGE, 8'($urandom), 2'($urandom), 9'($urandom));
        for (int i = 0; i < nbits; i++) begin
            if ($urandom_range(99) < 8) begin
                pick = $urandom_range(99);
                if (pick < 50) begin
                    rand_read();
                end else if (pick < 50 + rel_pct) begin
                    send_word(REQ_RELEASE, 8'($urandom), 2'($urandom), 9'($urandom));
                end else if (!sb.keep_toggle) begin
                    send_word(REQ_EDGE, 8'($urandom), 2'($urandom), 9'($urandom));
                end
            end
            send_word(REQ_BIT, 8'($urandom), 2'($urandom), 9'($urandom));
        end
    endtask

    // Mostly complete frames followed by a few reads; the rest are frames cut short
    // (the next kept edge abandons them) and words with entirely random content.
    task automatic random_phase(input int n_words, input int rel_pct);
        int stop;
        int pick;
        stop = words_sent + n_words;
        while (words_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                run_frame(FRAME_BITS, rel_pct);
                repeat ($urandom_range(3)) rand_read();
            end else if (pick < 80) begin
                run_frame($urandom_range(1, FRAME_BITS - 1), rel_pct);
            end else begin
                send_word(2'($urandom), 8'($urandom), 2'($urandom), 9'($urandom));
            end
        end
    endtask

    // Lowers valid and waits until every predicted result has come back, then lets
    // a stored frame's byte writes run out.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Writes both registers on consecutive cycles; only called while the block is idle.
    task automatic set_config(input logic rec, input logic [4:0] fpb);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_idx     <= CFG_REC_EN;
        i_cfg_wr_data <= {4'b0, rec};
        @(negedge i_clk);
        sb.write_cfg(CFG_REC_EN, {4'b0, rec});
        i_cfg_idx     <= CFG_FPB;
        i_cfg_wr_data <= fpb;
        @(negedge i_clk);
        sb.write_cfg(CFG_FPB, fpb);
        i_cfg_wr_en   <= 1'b0;
    endtask

    initial begin
        sb = new();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        set_config(1'b1, 5'd1);

        // Directed part. Releasing every block first clears every slot of the whole buffer, so that
        // no later read can ever return a byte that was never written.
        for (int b = 0; b < NUM_BLOCKS; b++)
            send_word(REQ_RELEASE, 8'h00, 2'(b), 9'd0);
        // A bit sample with no frame open is ignored.
        send_word(REQ_BIT, 8'hFF, 2'd3, 9'd511);
        // Reads below and beyond the frame area answer zero; one inside it too.
        send_word(REQ_READ, 8'hFF, 2'd3, 9'd511);
        send_word(REQ_READ, 8'h00, 2'd0, 9'd0);
        send_word(REQ_READ, 8'h00, 2'd1, 9'd1);
        send_word(REQ_READ, 8'h00, 2'd0, 9'd2);
        // First edge after reset is dropped, the second one opens a frame.
        send_word(REQ_EDGE, 8'h00, 2'd0, 9'd0);
        send_word(REQ_EDGE, 8'hFF, 2'd3, 9'd511);
        send_word(REQ_BIT, 8'hFF, 2'd0, 9'd0);
        send_word(REQ_BIT, 8'h00, 2'd0, 9'd0);
        // A dropped edge in the middle of a frame leaves it alone.
        send_word(REQ_EDGE, 8'h00, 2'd0, 9'd0);
        send_word(REQ_BIT, 8'hA5, 2'd0, 9'd0);
        // A kept edge in the middle of a frame throws it away and starts afresh.
        send_word(REQ_EDGE, 8'h00, 2'd0, 9'd0);
        send_word(REQ_BIT, 8'h5A, 2'd0, 9'd0);
        // Releasing the block that is being filled.
        send_word(REQ_RELEASE, 8'h00, 2'd0, 9'd0);
        send_word(REQ_READ, 8'h00, 2'd0, 9'd3);

        // Random part: the idling pattern rotates through none, sender gaps, receiver
        // stalls and both together, one per phase.
        for (int p = 0; p < N_PHASES; p++) begin
            drain();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            set_config(1'(ph_rec[p]), 5'(ph_fpb[p]));
            random_phase(ph_words[p], ph_rel[p]);
        end
        drain();

        if (sb.error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
